// ===== rtl/core/pam_pkg.sv =====
// shared types and constants for the polynomial add/multiply core
`default_nettype none
package pam_pkg;
   localparam int unsigned CoefInW  = 16;
   localparam int unsigned ExpInW   = 4;
   localparam int unsigned CoefOutW = 38;
   localparam int unsigned ExpOutW  = 5;
   localparam int unsigned FuncW    = 3;

   typedef enum logic [FuncW-1:0] {
      FUNC_LOAD_A  = 3'd0,
      FUNC_LOAD_B  = 3'd1,
      FUNC_SUM     = 3'd2,
      FUNC_PRODUCT = 3'd3,
      FUNC_CLEAR   = 3'd4
   } func_type;

   typedef struct packed {
      logic [FuncW-1:0]         func;
      logic signed [CoefInW-1:0] coef_in;
      logic [ExpInW-1:0]        exp_in;
   } req_type;

   typedef struct packed {
      logic signed [CoefOutW-1:0] coef_out;
      logic [ExpOutW-1:0]         exp_out;
      logic                       last;
      logic                       zero_poly;
   } rsp_type;

   // classified command passed from front to back
   typedef struct packed {
      logic                      load_a;
      logic                      load_b;
      logic                      do_sum;
      logic                      do_prod;
      logic                      do_clear;
      logic signed [CoefInW-1:0] coef;
      logic [ExpInW-1:0]         exp;
   } cmd_type;
endpackage
`default_nettype wire

// ===== rtl/core/pam_front.sv =====
// front end: accepts requests, classifies them, queues commands for the back end
`default_nettype none
module pam_front #(
   parameter int unsigned MAX_EXP = 15
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_push,
   output logic             req_full,
   input  pam_pkg::req_type req_data,
   output logic             cmd_valid,
   input  wire              cmd_take,
   output pam_pkg::cmd_type cmd_data
);
   localparam int unsigned Depth     = 2;
   localparam int unsigned ExpInWExt = pam_pkg::ExpInW + 1;

   pam_pkg::cmd_type q_ff [Depth];
   pam_pkg::cmd_type cls;
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       cnt_ff;
   logic             push_ok, keep;

   // classify the incoming request; drop ignored ones
   always_comb begin
      cls = '0;
      cls.coef = req_data.coef_in;
      cls.exp  = req_data.exp_in;
      case (req_data.func)
         pam_pkg::FUNC_LOAD_A:  cls.load_a   = ({1'b0, req_data.exp_in} <= (ExpInWExt)'(MAX_EXP))
                                               && (req_data.coef_in != '0);
         pam_pkg::FUNC_LOAD_B:  cls.load_b   = ({1'b0, req_data.exp_in} <= (ExpInWExt)'(MAX_EXP))
                                               && (req_data.coef_in != '0);
         pam_pkg::FUNC_SUM:     cls.do_sum   = 1'b1;
         pam_pkg::FUNC_PRODUCT: cls.do_prod  = 1'b1;
         pam_pkg::FUNC_CLEAR:   cls.do_clear = 1'b1;
         default:               cls = cls;
      endcase
      keep = cls.load_a | cls.load_b | cls.do_sum | cls.do_prod | cls.do_clear;
   end

   assign req_full  = (cnt_ff == 2'(Depth));
   assign push_ok   = req_push && !req_full && keep;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   // command queue
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push_ok) begin
            q_ff[wr_ptr_ff] <= cls;
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_take) rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + 2'(push_ok) - 2'(cmd_take);
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/pam_back.sv =====
// back end: coefficient stores, sum and multiply-accumulate engine, result queue
`default_nettype none
module pam_back #(
   parameter int unsigned MAX_EXP = 15
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              cmd_valid,
   output logic             cmd_take,
   input  pam_pkg::cmd_type cmd_data,
   output logic             rsp_empty,
   input  wire              rsp_pop,
   output pam_pkg::rsp_type rsp_data
);
   localparam int unsigned NTerms = MAX_EXP + 1;
   localparam int unsigned NProd  = 2 * MAX_EXP + 1;
   localparam int unsigned IW     = $clog2(NTerms);
   localparam int unsigned PW     = $clog2(NProd + 1);
   localparam int unsigned CW     = pam_pkg::CoefInW;
   localparam int unsigned OW     = pam_pkg::CoefOutW;

   typedef enum logic [2:0] {ST_IDLE, ST_MAC, ST_SCAN, ST_WAIT, ST_FLUSH} state_type;

   logic signed [CW-1:0]   a_ff [NTerms];
   logic signed [CW-1:0]   b_ff [NTerms];
   logic [NTerms-1:0]      av_ff, bv_ff;
   logic signed [OW-2:0]   p_ff [NProd];
   state_type              st_ff;
   logic                   prod_ff;
   logic [IW-1:0]          i_ff, j_ff;
   logic [PW-1:0]          k_ff;
   logic                   any_ff;
   pam_pkg::rsp_type       hold_ff;
   logic signed [2*CW-1:0] mul_ff;
   logic [PW-1:0]          mk_ff;
   logic                   mv_ff;
   logic                   mlast_ff;
   pam_pkg::rsp_type       out_ff;
   logic                   full_ff;

   logic [IW-1:0]          ld_idx;
   logic signed [CW-1:0]   ai, bj, ak, bk, cur;
   logic signed [CW-1:0]   sa, sb;
   logic signed [CW:0]     ld_sum;
   logic signed [CW-1:0]   ld_sat;
   logic signed [OW-1:0]   term;
   logic [PW-1:0]          next_nz;
   logic                   found;
   logic                   out_free;

   // stored operand reads (invalid entries read as zero)
   always_comb begin
      ld_idx = IW'(cmd_data.exp);
      ai  = av_ff[i_ff] ? a_ff[i_ff] : '0;
      bj  = bv_ff[j_ff] ? b_ff[j_ff] : '0;
      ak  = av_ff[ld_idx] ? a_ff[ld_idx] : '0;
      bk  = bv_ff[ld_idx] ? b_ff[ld_idx] : '0;
      cur = cmd_data.load_a ? ak : bk;
      ld_sum = CW'(1) == 0 ? '0 : ({cur[CW-1], cur} + {cmd_data.coef[CW-1], cmd_data.coef});
      if (ld_sum[CW] != ld_sum[CW-1])
         ld_sat = ld_sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      else
         ld_sat = ld_sum[CW-1:0];
   end

   // term under the scan pointer
   always_comb begin
      sa = av_ff[k_ff[IW-1:0]] ? a_ff[k_ff[IW-1:0]] : '0;
      sb = bv_ff[k_ff[IW-1:0]] ? b_ff[k_ff[IW-1:0]] : '0;
      if (prod_ff)
         term = OW'(p_ff[k_ff[PW-1:0] < PW'(NProd) ? k_ff : '0]);
      else if (k_ff < PW'(NTerms))
         term = OW'(sa) + OW'(sb);
      else
         term = '0;
      found   = (term != '0);
      next_nz = k_ff - PW'(1);
   end

   assign out_free  = !full_ff || rsp_pop;
   assign rsp_empty = !full_ff;
   assign rsp_data  = out_ff;
   assign cmd_take  = cmd_valid && (st_ff == ST_IDLE);

   // sequencer, stores and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         av_ff   <= '0;
         bv_ff   <= '0;
         full_ff <= 1'b0;
         mv_ff   <= 1'b0;
      end else begin
         if (rsp_pop && full_ff) full_ff <= 1'b0;
         mv_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  if (cmd_data.load_a) begin
                     a_ff[ld_idx]  <= ld_sat;
                     av_ff[ld_idx] <= 1'b1;
                  end
                  if (cmd_data.load_b) begin
                     b_ff[ld_idx]  <= ld_sat;
                     bv_ff[ld_idx] <= 1'b1;
                  end
                  if (cmd_data.do_clear) begin
                     av_ff <= '0;
                     bv_ff <= '0;
                  end
                  any_ff  <= 1'b0;
                  prod_ff <= cmd_data.do_prod;
                  if (cmd_data.do_sum) begin
                     k_ff  <= PW'(NTerms - 1);
                     st_ff <= ST_SCAN;
                  end
                  if (cmd_data.do_prod) begin
                     for (int n = 0; n < NProd; n++) p_ff[n] <= '0;
                     i_ff  <= '0;
                     j_ff  <= '0;
                     st_ff <= ST_MAC;
                  end
               end
            end
            ST_MAC: begin
               // one multiply a cycle, each product accumulated in the cycle after it
               mul_ff   <= ai * bj;
               mk_ff    <= PW'(i_ff) + PW'(j_ff);
               mv_ff    <= 1'b1;
               mlast_ff <= (i_ff == IW'(MAX_EXP)) && (j_ff == IW'(MAX_EXP));
               if (j_ff == IW'(MAX_EXP)) begin
                  j_ff <= '0;
                  i_ff <= i_ff + IW'(1);
               end else begin
                  j_ff <= j_ff + IW'(1);
               end
               if (mv_ff && mlast_ff) begin
                  mv_ff <= 1'b0;
                  k_ff  <= PW'(NProd - 1);
                  st_ff <= ST_WAIT;
               end
            end
            ST_WAIT: st_ff <= ST_SCAN;
            ST_SCAN: begin
               // a found term is held until the next one shows it is not last
               if (!found || !any_ff || out_free) begin
                  if (found) begin
                     if (any_ff) begin
                        out_ff  <= hold_ff;
                        full_ff <= 1'b1;
                     end
                     hold_ff <= '{coef_out: term, exp_out: pam_pkg::ExpOutW'(k_ff),
                                  last: 1'b0, zero_poly: 1'b0};
                     any_ff  <= 1'b1;
                  end
                  if (k_ff == '0) st_ff <= ST_FLUSH;
                  else            k_ff  <= next_nz;
               end
            end
            ST_FLUSH: begin
               // held term goes out as last, or the zero marker when none was found
               if (out_free) begin
                  if (any_ff)
                     out_ff <= '{coef_out: hold_ff.coef_out, exp_out: hold_ff.exp_out,
                                 last: 1'b1, zero_poly: 1'b0};
                  else
                     out_ff <= '{coef_out: '0, exp_out: '0, last: 1'b1, zero_poly: 1'b1};
                  full_ff <= 1'b1;
                  st_ff   <= ST_IDLE;
               end
            end
            default: st_ff <= ST_IDLE;
         endcase
         if (mv_ff) p_ff[mk_ff] <= p_ff[mk_ff] + (OW-1)'(mul_ff);
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/polynomial_add_multiply_core.sv =====
// top level of the polynomial add/multiply core
// sequence: the front queue registers each accepted request before the back end takes it; loads
// and clears update the stores then, no result; sum: a scan of the sum terms from the top exponent
// down and a flush; product: multiply-accumulate (one product a cycle), a drain state, a scan of
// the product terms from the top exponent down and a flush, which sends the last result
// throughput: one request at a time in the back end, two queued in front; a held result stalls the scan
// reset: synchronous, clears queues, stores read as zero afterward
`default_nettype none
module polynomial_add_multiply_core #(
   parameter int unsigned MAX_EXP = 15
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   output logic             full,
   input  pam_pkg::req_type req_data,
   output logic             empty,
   input  wire              pop,
   output pam_pkg::rsp_type rsp_data
);
   logic             cmd_valid, cmd_take;
   pam_pkg::cmd_type cmd_data;

   pam_front #(.MAX_EXP(MAX_EXP)) u_front (
      .clock, .reset, .req_push(push), .req_full(full), .req_data,
      .cmd_valid, .cmd_take, .cmd_data
   );

   pam_back #(.MAX_EXP(MAX_EXP)) u_back (
      .clock, .reset, .cmd_valid, .cmd_take, .cmd_data,
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data
   );
endmodule
`default_nettype wire

// ===== rtl/core/pam_checker.sv =====
// port-level checker bound to the core
`default_nettype none
module pam_checker (
   input wire              clock,
   input wire              reset,
   input wire              full,
   input wire              empty,
   input wire              pop,
   input pam_pkg::rsp_type rsp_data
);
   // zero result is always a single last term at exponent zero
   a_zero_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.zero_poly) |-> (rsp_data.last && rsp_data.exp_out == '0
      && rsp_data.coef_out == '0)) else $error("zero result malformed");
   // emitted nonzero terms carry a nonzero coefficient
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.zero_poly) |-> (rsp_data.coef_out != '0))
      else $error("zero coefficient emitted");
   // a waiting result holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(!empty && !pop) && !$past(reset)) |-> (!empty && $stable(rsp_data)))
      else $error("result changed while waiting");
   // reset leaves both sides idle
   a_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (empty && !full))
      else $error("not idle after reset");
endmodule

bind polynomial_add_multiply_core pam_checker u_pam_checker (
   .clock, .reset, .full, .empty, .pop, .rsp_data
);
`default_nettype wire

// ===== test/pam_checker.sv =====
// checker for the polynomial add/multiply core: predicts terms and compares results
module pam_scoreboard (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire               full,
   input  pam_pkg::req_type  req_data,
   input  wire               empty,
   input  wire               pop,
   input  pam_pkg::rsp_type  rsp_data,
   output int                fail_count,
   output int                pending_terms,
   output int                term_count
);
   localparam int NumTerms = 16;
   localparam int NumProd  = 31;

   logic signed [15:0] poly_a [NumTerms];
   logic signed [15:0] poly_b [NumTerms];
   pam_pkg::rsp_type   term_queue [$];
   int                 pushed_count;

   // saturating add into one stored term
   function automatic logic signed [15:0] sat_add(logic signed [15:0] old_v,
                                                  logic signed [15:0] add_v);
      logic signed [17:0] total;
      total = 18'(old_v) + 18'(add_v);
      if (total > 18'sd32767) return 16'sh7fff;
      if (total < -18'sd32768) return 16'sh8000;
      return total[15:0];
   endfunction

   // queue nonzero terms in descending exponent, or one zero marker
   task automatic queue_terms(input logic signed [37:0] terms [NumProd], input int count);
      pam_pkg::rsp_type t;
      int n;
      n = 0;
      for (int i = count - 1; i >= 0; i--) begin
         if (terms[i] != 0) begin
            t.coef_out = terms[i];
            t.exp_out = 5'(i);
            t.last = 1'b0;
            t.zero_poly = 1'b0;
            term_queue.push_back(t);
            n++;
         end
      end
      if (n == 0) begin
         t = '0;
         t.last = 1'b1;
         t.zero_poly = 1'b1;
         term_queue.push_back(t);
      end else begin
         term_queue[term_queue.size() - 1].last = 1'b1;
      end
   endtask

   // predict each accepted request
   always @(posedge clock) begin
      logic signed [37:0] acc [NumProd];
      int q_before;
      if (reset) begin
         for (int i = 0; i < NumTerms; i++) begin
            poly_a[i] <= '0;
            poly_b[i] <= '0;
         end
         pushed_count <= 0;
      end else if (push && !full) begin
         q_before = term_queue.size();
         case (req_data.func)
            pam_pkg::FUNC_LOAD_A: poly_a[req_data.exp_in] <=
               sat_add(poly_a[req_data.exp_in], req_data.coef_in);
            pam_pkg::FUNC_LOAD_B: poly_b[req_data.exp_in] <=
               sat_add(poly_b[req_data.exp_in], req_data.coef_in);
            pam_pkg::FUNC_SUM: begin
               for (int i = 0; i < NumProd; i++) acc[i] = '0;
               for (int i = 0; i < NumTerms; i++)
                  acc[i] = 38'(poly_a[i]) + 38'(poly_b[i]);
               queue_terms(acc, NumTerms);
            end
            pam_pkg::FUNC_PRODUCT: begin
               for (int i = 0; i < NumProd; i++) acc[i] = '0;
               for (int i = 0; i < NumTerms; i++)
                  for (int j = 0; j < NumTerms; j++)
                     acc[i + j] += 38'(poly_a[i]) * 38'(poly_b[j]);
               queue_terms(acc, NumProd);
            end
            pam_pkg::FUNC_CLEAR: begin
               for (int i = 0; i < NumTerms; i++) begin
                  poly_a[i] <= '0;
                  poly_b[i] <= '0;
               end
            end
            default: ;
         endcase
         pushed_count <= pushed_count + (term_queue.size() - q_before);
      end
   end

   // compare each accepted result term
   always @(posedge clock) begin
      pam_pkg::rsp_type exp_t;
      if (reset) begin
         fail_count <= 0;
         term_count <= 0;
      end else if (pop && !empty) begin
         term_count <= term_count + 1;
         if (term_queue.size() == 0) begin
            $display("%0t: unexpected term, actual %h", $time, rsp_data);
            fail_count <= fail_count + 1;
         end else begin
            exp_t = term_queue.pop_front();
            if (rsp_data !== exp_t) begin
               $display("%0t: term mismatch, expected coef %0d exp %0d last %b zero %b",
                        $time, exp_t.coef_out, exp_t.exp_out, exp_t.last, exp_t.zero_poly);
               $display("%0t:                actual coef %0d exp %0d last %b zero %b",
                        $time, rsp_data.coef_out, rsp_data.exp_out, rsp_data.last,
                        rsp_data.zero_poly);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   assign pending_terms = pushed_count - term_count;
endmodule

// ===== test/tb.sv =====
// testbench top for the polynomial add/multiply core: stimulus and verdict
module tb;
   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             push = 1'b0;
   logic             pop = 1'b0;
   logic             full, empty;
   pam_pkg::req_type req_data = '0;
   pam_pkg::rsp_type rsp_data;
   int               fail_count, pending_terms, term_count;
   int               send_idle = 0, recv_idle = 0;
   int               cycle_count = 0;
   int               sent = 0;

   always #5 clock = ~clock;

   polynomial_add_multiply_core DUT (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   pam_scoreboard checker_i (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending_terms(pending_terms), .term_count(term_count)
   );

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver with random stalls
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= recv_idle);
   end

   // send one request; push stays high until the caller idles or sends again
   task automatic send(input logic [2:0] f, input logic signed [15:0] c,
                       input logic [3:0] e);
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= {f, c, e};
      @(posedge clock);
      while (full) @(posedge clock);
      sent++;
   endtask

   // stop sending until every predicted result has been taken
   task automatic drain();
      push <= 1'b0;
      @(posedge clock);
      while (pending_terms != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   // a well-formed random sequence: loads then sum, product, clear or an ignored code
   task automatic random_set(input int n_loads);
      logic [15:0] c;
      for (int i = 0; i < n_loads; i++) begin
         case ($urandom_range(3))
            0: c = 16'($urandom);
            1: c = $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: c = 16'($signed(12'($urandom)));
         endcase
         send($urandom_range(1) ? pam_pkg::FUNC_LOAD_B : pam_pkg::FUNC_LOAD_A, c,
              4'($urandom));
      end
      case ($urandom_range(9))
         0: send(pam_pkg::FUNC_CLEAR, 16'($urandom), 4'($urandom));
         1: send(3'($urandom_range(7, 5)), 16'($urandom), 4'($urandom));
         2, 3, 4: send(pam_pkg::FUNC_SUM, 16'($urandom), 4'($urandom));
         default: send(pam_pkg::FUNC_PRODUCT, 16'($urandom), 4'($urandom));
      endcase
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: empty results, extremes, saturation, cancellation, odd codes
      send(pam_pkg::FUNC_SUM, 16'sh0, 4'd0);
      send(pam_pkg::FUNC_PRODUCT, 16'sh0, 4'd0);
      send(pam_pkg::FUNC_LOAD_A, 16'sh7fff, 4'd15);
      send(pam_pkg::FUNC_LOAD_A, 16'sh7fff, 4'd15);
      send(pam_pkg::FUNC_LOAD_B, 16'sh8000, 4'd15);
      send(pam_pkg::FUNC_LOAD_B, 16'sh8000, 4'd15);
      send(pam_pkg::FUNC_LOAD_A, 16'sh8000, 4'd0);
      send(pam_pkg::FUNC_LOAD_B, 16'sh8000, 4'd0);
      send(pam_pkg::FUNC_LOAD_A, 16'sh0, 4'd7);
      send(pam_pkg::FUNC_SUM, 16'sh0, 4'd0);
      send(pam_pkg::FUNC_PRODUCT, 16'sh0, 4'd0);
      send(pam_pkg::FUNC_LOAD_A, 16'sh0001, 4'd15);
      send(pam_pkg::FUNC_LOAD_A, 16'shffff, 4'd15);
      send(3'd5, 16'sh1234, 4'd3);
      send(3'd6, 16'shffff, 4'd15);
      send(3'd7, 16'sh5555, 4'd10);
      send(pam_pkg::FUNC_SUM, 16'shffff, 4'd15);
      send(pam_pkg::FUNC_CLEAR, 16'shaaaa, 4'd5);
      send(pam_pkg::FUNC_SUM, 16'sh0, 4'd0);
      send(pam_pkg::FUNC_LOAD_A, 16'sh0005, 4'd3);
      send(pam_pkg::FUNC_LOAD_B, 16'shfffb, 4'd3);
      send(pam_pkg::FUNC_SUM, 16'sh0, 4'd0);
      send(pam_pkg::FUNC_PRODUCT, 16'sh0, 4'd0);
      drain();
      // random: three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 11 : (phase == 1) ? 88 : 0;
         recv_idle = (phase == 0) ? 88 : (phase == 1) ? 11 : 0;
         for (int k = 0; k < 12; k++) begin
            random_set($urandom_range(6));
            if (k == 6) drain();
         end
         send(pam_pkg::FUNC_CLEAR, 16'sh0, 4'd0);
      end
      drain();
      $display("covered %0d requests and %0d result terms: loads with saturation,", sent,
               term_count);
      $display("sums, products, clears and ignored codes under three stall patterns");
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/pam_pkg.sv
rtl/core/pam_front.sv
rtl/core/pam_back.sv
rtl/core/polynomial_add_multiply_core.sv
rtl/core/pam_checker.sv
test/pam_checker.sv
test/tb.sv
